### rtl/core/kcsr_pkg.sv
// ----------------------------------------------------------------------------
// kcsr_pkg: shared types, constants and microcode for the key chord remapper
// Holds the key codes, register indexes, action codes and the control store
// that sequences one key event through the remapper datapath.
// ----------------------------------------------------------------------------
package kcsr_pkg;

   // port widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 5;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLD_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STORM_WINDOW   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPLACE_KEY    = 2'd2;

   // register reset values
   localparam logic [15:0] HOLD_THRESHOLD_RST = 16'd80;
   localparam logic [15:0] STORM_WINDOW_RST   = 16'd200;
   localparam logic [7:0]  REPLACE_KEY_RST    = 8'd45;

   // key codes of the chord
   localparam logic [7:0] KEY_LWIN   = 8'h5B;
   localparam logic [7:0] KEY_RWIN   = 8'h5C;
   localparam logic [7:0] KEY_LSHIFT = 8'hA0;
   localparam logic [7:0] KEY_RSHIFT = 8'hA1;
   localparam logic [7:0] KEY_S      = 8'h53;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      ACT_PASS    = 3'd0,
      ACT_SWALLOW = 3'd1,
      ACT_REPLAY  = 3'd2,
      ACT_PRESS   = 3'd3,
      ACT_RELEASE = 3'd4
   } act_type;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_WIN       = 2'd1,
      MODE_WIN_SHIFT = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_INJ,
      COND_STORM,
      COND_ACTIVE,
      COND_TIMEOUT,
      COND_MODE_WS,
      COND_WIN_DN,
      COND_WIN,
      COND_SH_DN,
      COND_WINSH_DN,
      COND_WINSH,
      COND_S_DN
   } cond_type;

   // one held key event
   typedef struct packed {
      logic       ext;
      logic       down;
      logic [7:0] scan;
      logic [7:0] key;
   } held_entry_type;

   // one control word
   typedef struct packed {
      cond_type cond;
      logic     inv;
      step_type target;
      logic     emit_en;
      act_type  emit;
      logic     last;
      logic     hold;
      logic     replay;
      logic     mode_en;
      mode_type mode_val;
      logic     chord_ld;
      logic     storm_ld;
   } ucode_word_type;

   // program labels
   localparam step_type U_CHK_INJ        = 5'd0;
   localparam step_type U_CHK_STORM      = 5'd1;
   localparam step_type U_CHK_ACTIVE     = 5'd2;
   localparam step_type U_CHK_TIMEOUT    = 5'd3;
   localparam step_type U_TIMEOUT_REPLAY = 5'd4;
   localparam step_type U_WIN_MODE       = 5'd5;
   localparam step_type U_WIN_WDN        = 5'd6;
   localparam step_type U_WIN_WREL       = 5'd7;
   localparam step_type U_WIN_SDN        = 5'd8;
   localparam step_type U_REPLAY_PASS    = 5'd9;
   localparam step_type U_WS_DN          = 5'd10;
   localparam step_type U_WS_REL         = 5'd11;
   localparam step_type U_WS_S           = 5'd12;
   localparam step_type U_MATCH_PRESS    = 5'd13;
   localparam step_type U_MATCH_RELEASE  = 5'd14;
   localparam step_type U_SWALLOW        = 5'd15;
   localparam step_type U_PASS           = 5'd16;
   localparam step_type U_IDLE           = 5'd17;
   localparam step_type U_IDLE_START     = 5'd18;
   localparam step_type U_HOLD_SWALLOW   = 5'd19;
   localparam step_type U_HOLD_REPLAY    = 5'd20;
   localparam step_type U_REPLAY_SWALLOW = 5'd21;
   localparam step_type U_HOLD_SHIFT     = 5'd22;

   // control store
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w          = '0;
      w.cond     = COND_NEVER;
      w.emit     = ACT_PASS;
      w.mode_val = MODE_IDLE;
      w.target   = U_CHK_INJ;
      unique case (step)
         U_CHK_INJ: begin
            w.cond = COND_INJ; w.target = U_PASS;
         end
         U_CHK_STORM: begin
            w.cond = COND_STORM; w.target = U_SWALLOW;
         end
         U_CHK_ACTIVE: begin
            w.cond = COND_ACTIVE; w.inv = 1'b1; w.target = U_IDLE;
         end
         U_CHK_TIMEOUT: begin
            w.cond = COND_TIMEOUT; w.inv = 1'b1; w.target = U_WIN_MODE;
         end
         U_TIMEOUT_REPLAY: begin
            w.replay = 1'b1; w.cond = COND_ALWAYS; w.target = U_IDLE;
         end
         U_WIN_MODE: begin
            w.cond = COND_MODE_WS; w.target = U_WS_DN;
         end
         U_WIN_WDN: begin
            w.cond = COND_WIN_DN; w.target = U_HOLD_SWALLOW;
         end
         U_WIN_WREL: begin
            w.cond = COND_WIN; w.target = U_HOLD_REPLAY;
         end
         U_WIN_SDN: begin
            w.cond = COND_SH_DN; w.target = U_HOLD_SHIFT;
         end
         U_REPLAY_PASS: begin
            w.replay = 1'b1; w.cond = COND_ALWAYS; w.target = U_PASS;
         end
         U_WS_DN: begin
            w.cond = COND_WINSH_DN; w.target = U_HOLD_SWALLOW;
         end
         U_WS_REL: begin
            w.cond = COND_WINSH; w.target = U_HOLD_REPLAY;
         end
         U_WS_S: begin
            w.cond = COND_S_DN; w.inv = 1'b1; w.target = U_REPLAY_PASS;
         end
         U_MATCH_PRESS: begin
            w.storm_ld = 1'b1; w.emit_en = 1'b1; w.emit = ACT_PRESS;
         end
         U_MATCH_RELEASE: begin
            w.emit_en = 1'b1; w.emit = ACT_RELEASE;
         end
         U_SWALLOW: begin
            w.emit_en = 1'b1; w.emit = ACT_SWALLOW; w.last = 1'b1;
         end
         U_PASS: begin
            w.emit_en = 1'b1; w.emit = ACT_PASS; w.last = 1'b1;
         end
         U_IDLE: begin
            w.mode_en = 1'b1; w.mode_val = MODE_IDLE;
            w.cond = COND_WIN_DN; w.inv = 1'b1; w.target = U_PASS;
         end
         U_IDLE_START: begin
            w.chord_ld = 1'b1; w.hold = 1'b1;
            w.mode_en = 1'b1; w.mode_val = MODE_WIN;
            w.cond = COND_ALWAYS; w.target = U_SWALLOW;
         end
         U_HOLD_SWALLOW: begin
            w.hold = 1'b1; w.cond = COND_ALWAYS; w.target = U_SWALLOW;
         end
         U_HOLD_REPLAY: begin
            w.hold = 1'b1;
         end
         U_REPLAY_SWALLOW: begin
            w.replay = 1'b1; w.cond = COND_ALWAYS; w.target = U_SWALLOW;
         end
         U_HOLD_SHIFT: begin
            w.hold = 1'b1; w.mode_en = 1'b1; w.mode_val = MODE_WIN_SHIFT;
            w.cond = COND_ALWAYS; w.target = U_SWALLOW;
         end
         default: begin
            w.emit_en = 1'b1; w.emit = ACT_PASS; w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/core/key_chord_sequence_remapper_core.sv
// ----------------------------------------------------------------------------
// key_chord_sequence_remapper_core: fast Win, Shift, S chord to single key
// Holds back chord candidates, replaces a complete chord by a press and a
// release of the replacement key, and replays held events otherwise.
// ----------------------------------------------------------------------------
// Usage
//   req_ carries one key event per word; rsp_ returns, for each event, any
//   replayed or replacement words followed by one word with rsp_tlast high
//   that gives the disposition of the event itself (pass or swallow).
//   csr_ writes the threshold, storm window and replacement key while idle.
// Sequencing and throughput
//   Each event runs through a microcode program of 2 to 11 control steps,
//   one step per cycle while rsp_ is ready; a replay step holds until every
//   held event has been read and sent; replays stream at one word per cycle
//   while rsp_ is ready, from the registered read port of the hold buffer.
//   One event is in flight at a time: req_tready is high while no program runs.
// Reset
//   Registers return to 80 ms, 200 ms and key 45, the chord state goes idle
//   and the hold buffer is empty; no clearing pass is needed.
// Stalls
//   A low rsp_tready holds the output register and freezes the program at
//   its next emitting step; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module key_chord_sequence_remapper_core #(
   parameter int HOLD_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // key_code[7:0], scan_code[15:8], is_down[16], extended[17], time_ms[49:18]
   input  logic [kcsr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // injected[0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // out_key[7:0], out_scan[15:8], is_release[16], out_extended[17]
   output logic [kcsr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // action[2:0]
   output logic [kcsr_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [kcsr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [kcsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kcsr_pkg::*;

   localparam int IDX_W = $clog2(HOLD_DEPTH);
   localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

   // configuration
   logic [15:0] thr_ff, thr_in;
   logic [15:0] win_ff, win_in;
   logic [7:0]  rkey_ff, rkey_in;

   // sequencer and chord state
   logic                busy_ff, busy_in;
   step_type            step_ff, step_in;
   mode_type            mode_ff, mode_in;
   logic [31:0]         chord_ff, chord_in;
   logic [31:0]         storm_ff, storm_in;
   logic                armed_ff, armed_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, rd_vld_in;

   // latched event
   logic [7:0]  key_ff, key_in;
   logic [7:0]  scan_ff, scan_in;
   logic        down_ff, down_in;
   logic        ext_ff, ext_in;
   logic        inj_ff, inj_in;
   logic [31:0] now_ff, now_in;

   // output register
   logic        ovld_ff, ovld_in;
   act_type     oact_ff, oact_in;
   logic [7:0]  okey_ff, okey_in;
   logic [7:0]  oscan_ff, oscan_in;
   logic        orel_ff, orel_in;
   logic        oext_ff, oext_in;
   logic        olast_ff, olast_in;

   ucode_word_type uw;
   logic           req_fire, out_free, go, cond_hit, jump;
   logic           is_win, is_sh, is_s, storm_hit, timeout;
   logic [31:0]    storm_diff, chord_diff;
   logic           rp_act, rp_emit, rp_issue, rp_done, hold_we;
   held_entry_type hold_wdata, rd_data;

   // hold buffer
   kcsr_hold_buf #(
      .DEPTH (HOLD_DEPTH)
   ) u_hold_buf (
      .clock   (clock),
      .wr_en   (hold_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (hold_wdata),
      .rd_en   (rp_issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // control word fetch
   assign uw = ucode_rom(step_ff);

   // key classification and window compares
   assign is_win     = (key_ff == KEY_LWIN) || (key_ff == KEY_RWIN);
   assign is_sh      = (key_ff == KEY_LSHIFT) || (key_ff == KEY_RSHIFT);
   assign is_s       = (key_ff == KEY_S);
   assign storm_diff = now_ff - storm_ff;
   assign chord_diff = now_ff - chord_ff;
   assign storm_hit  = armed_ff && (storm_diff < {16'd0, win_ff}) && (is_win || is_sh || is_s);
   assign timeout    = chord_diff > {16'd0, thr_ff};

   // branch condition select
   always_comb begin
      case (uw.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_INJ:      cond_hit = inj_ff;
         COND_STORM:    cond_hit = storm_hit;
         COND_ACTIVE:   cond_hit = (mode_ff == MODE_WIN) || (mode_ff == MODE_WIN_SHIFT);
         COND_TIMEOUT:  cond_hit = timeout;
         COND_MODE_WS:  cond_hit = (mode_ff == MODE_WIN_SHIFT);
         COND_WIN_DN:   cond_hit = is_win && down_ff;
         COND_WIN:      cond_hit = is_win;
         COND_SH_DN:    cond_hit = is_sh && down_ff;
         COND_WINSH_DN: cond_hit = (is_win || is_sh) && down_ff;
         COND_WINSH:    cond_hit = is_win || is_sh;
         COND_S_DN:     cond_hit = is_s && down_ff;
         default:       cond_hit = 1'b0;
      endcase
   end
   assign jump = (uw.cond != COND_NEVER) && (cond_hit ^ uw.inv);

   // handshakes and step advance
   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && !busy_ff;
   assign out_free   = !ovld_ff || rsp_tready;

   // replay streaming: one read in flight, one word out per cycle while the output is free
   assign rp_act   = busy_ff && uw.replay;
   assign rp_emit  = rp_act && rd_vld_ff && out_free;
   assign rp_issue = rp_act && (rd_idx_ff < count_ff) && (!rd_vld_ff || rp_emit);
   assign rp_done  = rp_act && (rd_idx_ff == count_ff) && !rd_vld_ff;

   assign go = busy_ff && (uw.replay ? rp_done : (!uw.emit_en || out_free));

   // hold write
   assign hold_we    = go && uw.hold && (count_ff < CNT_W'(HOLD_DEPTH));
   assign hold_wdata = '{ext: ext_ff, down: down_ff, scan: scan_ff, key: key_ff};

   // next state
   always_comb begin
      thr_in    = thr_ff;
      win_in    = win_ff;
      rkey_in   = rkey_ff;
      busy_in   = busy_ff;
      step_in   = step_ff;
      mode_in   = mode_ff;
      chord_in  = chord_ff;
      storm_in  = storm_ff;
      armed_in  = armed_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      rd_vld_in = rd_vld_ff;
      key_in    = key_ff;
      scan_in   = scan_ff;
      down_in   = down_ff;
      ext_in    = ext_ff;
      inj_in    = inj_ff;
      now_in    = now_ff;
      ovld_in   = ovld_ff;
      oact_in   = oact_ff;
      okey_in   = okey_ff;
      oscan_in  = oscan_ff;
      orel_in   = orel_ff;
      oext_in   = oext_ff;
      olast_in  = olast_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_HOLD_THRESHOLD: thr_in  = csr_wdata;
            CSR_STORM_WINDOW:   win_in  = csr_wdata;
            CSR_REPLACE_KEY:    rkey_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      // event capture
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = U_CHK_INJ;
         key_in  = req_tdata[7:0];
         scan_in = req_tdata[15:8];
         down_in = req_tdata[16];
         ext_in  = req_tdata[17];
         now_in  = req_tdata[49:18];
         inj_in  = req_tuser;
      end

      // step execution
      if (go) begin
         step_in = jump ? uw.target : step_ff + STEP_W'(1);
         if (uw.last) begin
            busy_in = 1'b0;
         end
         if (uw.mode_en) begin
            mode_in = uw.mode_val;
         end
         if (uw.chord_ld) begin
            chord_in = now_ff;
         end
         if (uw.storm_ld) begin
            storm_in = now_ff;
            armed_in = 1'b1;
            count_in = '0;
            mode_in  = MODE_IDLE;
         end
      end
      if (hold_we) begin
         count_in = count_ff + CNT_W'(1);
      end

      // replay read pointer
      if (rp_issue) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
         rd_vld_in = 1'b1;
      end else if (rp_emit) begin
         rd_vld_in = 1'b0;
      end
      if (rp_done) begin
         rd_idx_in = '0;
         count_in  = '0;
         mode_in   = MODE_IDLE;
      end

      // output word
      if (ovld_ff && rsp_tready) begin
         ovld_in = 1'b0;
      end
      if (rp_emit) begin
         ovld_in  = 1'b1;
         oact_in  = ACT_REPLAY;
         okey_in  = rd_data.key;
         oscan_in = rd_data.scan;
         orel_in  = !rd_data.down;
         oext_in  = rd_data.ext;
         olast_in = 1'b0;
      end else if (go && uw.emit_en) begin
         ovld_in  = 1'b1;
         oact_in  = uw.emit;
         okey_in  = ((uw.emit == ACT_PRESS) || (uw.emit == ACT_RELEASE)) ? rkey_ff : 8'd0;
         oscan_in = 8'd0;
         orel_in  = (uw.emit == ACT_RELEASE);
         oext_in  = 1'b0;
         olast_in = uw.last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= HOLD_THRESHOLD_RST;
         win_ff    <= STORM_WINDOW_RST;
         rkey_ff   <= REPLACE_KEY_RST;
         busy_ff   <= 1'b0;
         step_ff   <= U_CHK_INJ;
         mode_ff   <= MODE_IDLE;
         chord_ff  <= '0;
         storm_ff  <= '0;
         armed_ff  <= 1'b0;
         count_ff  <= '0;
         rd_idx_ff <= '0;
         rd_vld_ff <= 1'b0;
         ovld_ff   <= 1'b0;
      end else begin
         thr_ff    <= thr_in;
         win_ff    <= win_in;
         rkey_ff   <= rkey_in;
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         mode_ff   <= mode_in;
         chord_ff  <= chord_in;
         storm_ff  <= storm_in;
         armed_ff  <= armed_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         rd_vld_ff <= rd_vld_in;
         ovld_ff   <= ovld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      scan_ff  <= scan_in;
      down_ff  <= down_in;
      ext_ff   <= ext_in;
      inj_ff   <= inj_in;
      now_ff   <= now_in;
      oact_ff  <= oact_in;
      okey_ff  <= okey_in;
      oscan_ff <= oscan_in;
      orel_ff  <= orel_in;
      oext_ff  <= oext_in;
      olast_ff <= olast_in;
   end

   // result port
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {6'd0, oext_ff, orel_ff, oscan_ff, okey_ff};
   assign rsp_tuser  = oact_ff;
   assign rsp_tlast  = olast_ff;

endmodule

### rtl/core/kcsr_hold_buf.sv
// ----------------------------------------------------------------------------
// kcsr_hold_buf: held key event store
// One write port and one read port with registered read data; holds the
// candidate events of a chord until they are dropped or replayed.
// ----------------------------------------------------------------------------
module kcsr_hold_buf #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  kcsr_pkg::held_entry_type     wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output kcsr_pkg::held_entry_type     rd_data
);
   import kcsr_pkg::*;

   held_entry_type mem [DEPTH];
   held_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/key_chord_sequence_remapper_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_chord_sequence_remapper_core_tb: self-checking bench for the remapper
// Drives timestamped key events into the req_ stream and predicts, event by
// event, the replayed, replacement and disposition words on the rsp_ stream.
// Directed tests cover injection, matches, storm swallowing, broken chords,
// timeouts, zero and maximum registers and a full hold buffer; random traffic
// follows under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module key_chord_sequence_remapper_core_tb;
   import kcsr_pkg::*;

   localparam int HOLD_DEPTH    = 16;
   localparam int SETTLE_CYCLES = 30;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int IDLE_PCT      = 27;
   localparam logic [7:0] KEY_A = 8'h41;

   typedef struct {
      logic [7:0]  key;
      logic [7:0]  scan;
      logic        down;
      logic        ext;
      logic        inj;
      logic [31:0] ts;
   } key_event_type;

   typedef struct {
      act_type    action;
      logic [7:0] key;
      logic [7:0] scan;
      logic       rel;
      logic       ext;
      logic       tlast;
   } rsp_word_type;

   // dut ports
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = CSR_HOLD_THRESHOLD;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // register mirror
   logic [15:0] hold_threshold_ms = HOLD_THRESHOLD_RST;
   logic [15:0] storm_window_ms   = STORM_WINDOW_RST;
   logic [7:0]  replacement_key   = REPLACE_KEY_RST;

   // chord tracker state
   mode_type       chord_mode     = MODE_IDLE;
   logic [31:0]    chord_start_ms = '0;
   logic [31:0]    storm_start_ms = '0;
   logic           storm_armed    = 1'b0;
   held_entry_type held_keys [HOLD_DEPTH];
   int             held_count     = 0;

   rsp_word_type expected_words [$];

   logic        calm   = 1'b0;
   logic [31:0] now_ms = '0;
   int errors         = 0;
   int items_sent     = 0;
   int words_checked  = 0;
   int chords_matched = 0;
   int words_replayed = 0;
   int settings_used  = 1;
   int quiet_cycles   = 0;

   key_chord_sequence_remapper_core #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // chord prediction
   // ---------------------------------------------------------------------
   function automatic void push_word(act_type act, logic [7:0] key, logic [7:0] scan,
                                     logic rel, logic ext, logic tlast);
      rsp_word_type w;
      w.action = act;
      w.key    = key;
      w.scan   = scan;
      w.rel    = rel;
      w.ext    = ext;
      w.tlast  = tlast;
      expected_words.push_back(w);
   endfunction

   function automatic void hold_key(key_event_type ev);
      if (held_count < HOLD_DEPTH) begin
         held_keys[held_count] = '{ext: ev.ext, down: ev.down, scan: ev.scan, key: ev.key};
         held_count++;
      end
   endfunction

   function automatic void replay_held();
      for (int i = 0; i < held_count; i++) begin
         push_word(ACT_REPLAY, held_keys[i].key, held_keys[i].scan,
                   ~held_keys[i].down, held_keys[i].ext, 1'b0);
         words_replayed++;
      end
      held_count = 0;
      chord_mode = MODE_IDLE;
   endfunction

   function automatic void predict_event(key_event_type ev);
      logic        is_win, is_sh, is_s;
      logic [31:0] since_storm, since_chord;
      is_win      = (ev.key == KEY_LWIN) || (ev.key == KEY_RWIN);
      is_sh       = (ev.key == KEY_LSHIFT) || (ev.key == KEY_RSHIFT);
      is_s        = (ev.key == KEY_S);
      since_storm = ev.ts - storm_start_ms;
      since_chord = ev.ts - chord_start_ms;

      // synthesised events always pass
      if (ev.inj) begin
         push_word(ACT_PASS, '0, '0, 1'b0, 1'b0, 1'b1);
         return;
      end
      // residual chord keys inside the storm window
      if (storm_armed && since_storm < {16'd0, storm_window_ms} && (is_win || is_sh || is_s)) begin
         push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
         return;
      end
      // chord too slow: flush and evaluate this event again from idle
      if ((chord_mode == MODE_WIN || chord_mode == MODE_WIN_SHIFT) &&
          since_chord > {16'd0, hold_threshold_ms})
         replay_held();

      case (chord_mode)
         MODE_WIN: begin
            if (is_win && ev.down) begin
               hold_key(ev);
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else if (is_win) begin
               hold_key(ev);
               replay_held();
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else if (is_sh && ev.down) begin
               hold_key(ev);
               chord_mode = MODE_WIN_SHIFT;
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               replay_held();
               push_word(ACT_PASS, '0, '0, 1'b0, 1'b0, 1'b1);
            end
         end
         MODE_WIN_SHIFT: begin
            if ((is_win || is_sh) && ev.down) begin
               hold_key(ev);
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else if (is_win || is_sh) begin
               hold_key(ev);
               replay_held();
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else if (is_s && ev.down) begin
               // chord complete: drop held keys, emit the replacement key
               storm_start_ms = ev.ts;
               storm_armed    = 1'b1;
               held_count     = 0;
               chord_mode     = MODE_IDLE;
               chords_matched++;
               push_word(ACT_PRESS, replacement_key, '0, 1'b0, 1'b0, 1'b0);
               push_word(ACT_RELEASE, replacement_key, '0, 1'b1, 1'b0, 1'b0);
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               replay_held();
               push_word(ACT_PASS, '0, '0, 1'b0, 1'b0, 1'b1);
            end
         end
         default: begin
            chord_mode = MODE_IDLE;
            if (is_win && ev.down) begin
               chord_start_ms = ev.ts;
               hold_key(ev);
               chord_mode = MODE_WIN;
               push_word(ACT_SWALLOW, '0, '0, 1'b0, 1'b0, 1'b1);
            end else begin
               push_word(ACT_PASS, '0, '0, 1'b0, 1'b0, 1'b1);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected rsp word: action %0d, tdata %h", rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = expected_words.pop_front();
            compare_field("action", 8'(want.action), 8'(rsp_tuser));
            compare_field("out_key", want.key, rsp_tdata[7:0]);
            compare_field("out_scan", want.scan, rsp_tdata[15:8]);
            compare_field("is_release", 8'(want.rel), 8'(rsp_tdata[16]));
            compare_field("out_extended", 8'(want.ext), 8'(rsp_tdata[17]));
            compare_field("last", 8'(want.tlast), 8'(rsp_tlast));
            words_checked++;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (calm)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("[key_chord_sequence_remapper_core] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic key_event_type make_event(logic [7:0] key, logic down, logic inj);
      key_event_type ev;
      ev.key  = key;
      ev.scan = 8'($urandom_range(0, 255));
      ev.down = down;
      ev.ext  = 1'($urandom_range(0, 1));
      ev.inj  = inj;
      ev.ts   = now_ms;
      return ev;
   endfunction

   function automatic logic [7:0] pick_chord_key();
      case ($urandom_range(0, 4))
         0: return KEY_LWIN;
         1: return KEY_RWIN;
         2: return KEY_LSHIFT;
         3: return KEY_RSHIFT;
         default: return KEY_S;
      endcase
   endfunction

   // one event word on req_, with random idle cycles in front of it
   task automatic send_event(input key_event_type ev);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {6'd0, ev.ts, ev.ext, ev.down, ev.scan, ev.key};
      req_tuser  <= ev.inj;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_event(ev);
      items_sent++;
   endtask

   task automatic send_key(input logic [7:0] key, input logic down);
      send_event(make_event(key, down, 1'b0));
   endtask

   // stop sending until every predicted word is back, then let things settle
   task automatic wait_results_done(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic set_registers(input logic [15:0] thr, input logic [15:0] storm,
                                input logic [7:0] rkey);
      wait_results_done(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_HOLD_THRESHOLD;
      csr_wdata <= thr;
      @(negedge clock);
      csr_addr  <= CSR_STORM_WINDOW;
      csr_wdata <= storm;
      @(negedge clock);
      csr_addr  <= CSR_REPLACE_KEY;
      csr_wdata <= {8'd0, rkey};
      @(negedge clock);
      csr_we <= 1'b0;
      hold_threshold_ms = thr;
      storm_window_ms   = storm;
      replacement_key   = rkey;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------
   task automatic test_pass_and_inject();
      key_event_type ev;
      // injected event with every field at its top value
      now_ms = 32'hFFFF_FFFF;
      ev = '{key: 8'hFF, scan: 8'hFF, down: 1'b1, ext: 1'b1, inj: 1'b1, ts: now_ms};
      send_event(ev);
      // plain event with every field at zero
      now_ms = '0;
      ev = '{key: 8'h00, scan: 8'h00, down: 1'b0, ext: 1'b0, inj: 1'b0, ts: now_ms};
      send_event(ev);
   endtask

   task automatic test_chord_match();
      now_ms = 32'd1000;
      send_key(KEY_LWIN, 1'b1);
      now_ms += 10;
      send_key(KEY_LSHIFT, 1'b1);
      now_ms += 10;
      send_key(KEY_S, 1'b1);
      // storm window swallows residual chord keys, injected ones still pass
      now_ms += 5;
      send_key(KEY_S, 1'b0);
      send_event(make_event(KEY_RWIN, 1'b1, 1'b1));
      send_key(KEY_A, 1'b1);
   endtask

   task automatic test_broken_chords();
      // win then an unrelated key
      now_ms = 32'd2000;
      send_key(KEY_RWIN, 1'b1);
      send_key(KEY_A, 1'b1);
      // win shift then win release
      now_ms += 5;
      send_key(KEY_LWIN, 1'b1);
      send_key(KEY_RSHIFT, 1'b1);
      send_key(KEY_LWIN, 1'b0);
      // too slow: flush, then the late win starts a new chord
      now_ms += 5;
      send_key(KEY_LWIN, 1'b1);
      now_ms += 32'(hold_threshold_ms) + 1;
      send_key(KEY_RWIN, 1'b1);
      send_key(KEY_S, 1'b1);
   endtask

   task automatic test_zero_settings();
      set_registers(16'd0, 16'd0, 8'd0);
      now_ms = 32'd5000;
      send_key(KEY_RWIN, 1'b1);
      send_key(KEY_LSHIFT, 1'b1);
      send_key(KEY_S, 1'b1);
      // zero storm window: S passes right after the match
      send_key(KEY_S, 1'b1);
      // zero threshold: one ms late is a timeout
      send_key(KEY_LWIN, 1'b1);
      now_ms += 1;
      send_key(KEY_RSHIFT, 1'b1);
   endtask

   task automatic test_full_hold_buffer();
      set_registers(16'hFFFF, 16'hFFFF, 8'hFF);
      // timestamps run across the 32-bit wrap
      now_ms = 32'hFFFF_FFF0;
      send_key(KEY_LWIN, 1'b1);
      now_ms += 2;
      send_key(KEY_LSHIFT, 1'b1);
      for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
         now_ms += 2;
         send_key(i[0] ? KEY_RWIN : KEY_RSHIFT, 1'b1);
      end
      send_key(KEY_A, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // random traffic under one register setting
   // ---------------------------------------------------------------------
   task automatic test_random_traffic(input int n_items, input logic [15:0] thr,
                                      input logic [15:0] storm, input logic [7:0] rkey,
                                      input logic no_idle);
      int   first, span, pick;
      logic paused;
      set_registers(thr, storm, rkey);
      calm   = no_idle;
      first  = items_sent;
      paused = 1'b0;
      while (items_sent - first < n_items) begin
         // sender holds off once until the block has drained
         if (!paused && items_sent - first >= n_items / 2) begin
            wait_results_done(0);
            paused = 1'b1;
         end
         span = int'(hold_threshold_ms) / 3;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // well-formed chord, often after the storm window has run out
            if ($urandom_range(0, 1))
               now_ms += 32'(storm_window_ms) + $urandom_range(0, 100);
            else
               now_ms += $urandom_range(0, 100);
            send_key($urandom_range(0, 1) ? KEY_RWIN : KEY_LWIN, 1'b1);
            if ($urandom_range(0, 4) == 0) begin
               now_ms += $urandom_range(0, span);
               send_key($urandom_range(0, 1) ? KEY_RWIN : KEY_LWIN, 1'b1);
            end
            now_ms += $urandom_range(0, span);
            send_key($urandom_range(0, 1) ? KEY_RSHIFT : KEY_LSHIFT, 1'b1);
            if ($urandom_range(0, 4) == 0) begin
               now_ms += $urandom_range(0, span);
               send_key($urandom_range(0, 1) ? KEY_RSHIFT : KEY_LSHIFT, 1'b1);
            end
            now_ms += $urandom_range(0, span);
            send_key(KEY_S, 1'b1);
            // trailing releases
            repeat ($urandom_range(0, 3)) begin
               now_ms += $urandom_range(0, 30);
               send_key(pick_chord_key(), 1'($urandom_range(0, 3) == 0));
            end
         end else if (pick < 65) begin
            // chord broken part way
            now_ms += 32'(storm_window_ms) + $urandom_range(0, 50);
            send_key($urandom_range(0, 1) ? KEY_RWIN : KEY_LWIN, 1'b1);
            if ($urandom_range(0, 1)) begin
               now_ms += $urandom_range(0, span);
               send_key($urandom_range(0, 1) ? KEY_RSHIFT : KEY_LSHIFT, 1'b1);
            end
            case ($urandom_range(0, 3))
               0: send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               1: send_key($urandom_range(0, 1) ? KEY_RWIN : KEY_LWIN, 1'b0);
               2: send_key($urandom_range(0, 1) ? KEY_RSHIFT : KEY_LSHIFT, 1'b0);
               default: begin
                  now_ms += 32'(hold_threshold_ms) + 1 + $urandom_range(0, 50);
                  send_key(pick_chord_key(), 1'($urandom_range(0, 1)));
               end
            endcase
         end else if (pick < 80) begin
            // arbitrary key event
            now_ms += $urandom_range(0, 200);
            send_event(make_event(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 7) == 0)));
         end else if (pick < 90) begin
            // injected event, often a chord key
            now_ms += $urandom_range(0, 50);
            send_event(make_event($urandom_range(0, 1) ? pick_chord_key()
                                                       : 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'b1));
         end else begin
            // timestamp jump anywhere in the 32-bit range
            now_ms = $urandom();
            send_key(pick_chord_key(), 1'($urandom_range(0, 1)));
         end
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pass_and_inject();
      test_chord_match();
      test_broken_chords();
      test_zero_settings();
      test_full_hold_buffer();
      test_random_traffic(35, 16'($urandom_range(20, 120)), 16'($urandom_range(50, 300)),
                          8'($urandom_range(0, 255)), 1'b0);
      test_random_traffic(35, 16'd0, 16'd0, 8'd0, 1'b1);
      test_random_traffic(35, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
      test_random_traffic(35, 16'($urandom_range(1, 400)), 16'($urandom_range(0, 600)),
                          8'($urandom_range(0, 255)), 1'b0);

      wait_results_done(SETTLE_CYCLES);
      $display("sent %0d key events under %0d register settings, checked %0d rsp words",
               items_sent, settings_used, words_checked);
      $display("including %0d chord matches and %0d replayed events",
               chords_matched, words_replayed);
      if (errors == 0)
         $display("[key_chord_sequence_remapper_core] OK");
      else
         $display("[key_chord_sequence_remapper_core] ERROR");
      $finish;
   end

endmodule
